/* src/tail_drop_packet_buffer_unit_macros.svh */
// Assertion macros shared by the packet buffer RTL.
`ifndef TAIL_DROP_PACKET_BUFFER_UNIT_MACROS_SVH
`define TAIL_DROP_PACKET_BUFFER_UNIT_MACROS_SVH

// Implication in the same cycle, ignored during reset.
`define TDPB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, ignored during reset.
`define TDPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tdpb_pkg.sv */
// Shared types and constants of the tail-drop packet buffer.
`default_nettype none
package tdpb_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;

    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned SERVICE_W = 16;
    localparam int unsigned CAP_W     = 7;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Register index of buffer_capacity
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

endpackage
`default_nettype wire

/* src/tail_drop_packet_buffer_unit.sv */
// Top level of the tail-drop packet buffer: sequencer, finish-time ring and register port.
`default_nettype none
`include "tail_drop_packet_buffer_unit_macros.svh"

// Tail-drop packet buffer with a single server. Raise i_start with a packet
// (arrival stamp and service length) while o_busy is low; the packet beat is
// taken at that edge. One result beat follows per packet, shown for exactly
// one cycle with o_done high: o_dropped set and o_start_stamp zero when the
// buffer was full, else the start time. The receiver cannot stall, so sample
// the result whenever o_done is high. Finish times sit in a ring memory with a
// registered read; retirement walks the ring from the head one entry per cycle,
// and that walk sets the rate. Each packet passes the read, check and decide
// states in turn (check is skipped for an empty ring and repeats while the head
// retires). o_busy drops in the cycle the result is shown, so the next packet
// may be taken then. The capacity register sits at byte address 0 of the
// APB-style port; write it only while the block is idle.
// The ring needs no clearing pass: only occupied entries are ever read.
module tail_drop_packet_buffer_unit #(
    parameter int unsigned DEPTH = tdpb_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // packet command
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [tdpb_pkg::STAMP_W-1:0]    i_arrival_stamp,
    input  wire logic [tdpb_pkg::SERVICE_W-1:0]  i_service_length,
    // result strobe
    output logic                                 o_done,
    output logic                                 o_dropped,
    output logic [tdpb_pkg::STAMP_W-1:0]         o_start_stamp,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tdpb_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [tdpb_pkg::DATA_W-1:0]     pwdata,
    output logic [tdpb_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > tdpb_pkg::CAP_W) ? CW : tdpb_pkg::CAP_W;
    localparam int unsigned SW   = ((AW > CW) ? AW : CW) + 1;

    localparam logic [AW-1:0]   HEAD_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0]   OCC_FULL  = CW'(DEPTH);
    localparam logic [SW-1:0]   SUM_DEPTH = SW'(DEPTH);

    // ---------------------------------------------------------------
    // Register port: pready always high, capacity at index 0
    // ---------------------------------------------------------------
    logic [tdpb_pkg::CAP_W-1:0] r_capacity;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == tdpb_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tdpb_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[tdpb_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == tdpb_pkg::REG_CAPACITY) begin
            prdata = {{(tdpb_pkg::DATA_W - tdpb_pkg::CAP_W){1'b0}}, r_capacity};
        end else begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    tdpb_pkg::t_state r_state, n_state;

    logic [AW-1:0]                     r_head, n_head;
    logic [CW-1:0]                     r_occ, n_occ;
    logic [tdpb_pkg::STAMP_W-1:0]      r_last, n_last;     // finish time at the tail
    logic [tdpb_pkg::STAMP_W-1:0]      r_arrival;
    logic [tdpb_pkg::SERVICE_W-1:0]    r_service;

    logic                              r_done, n_done;
    logic                              r_dropped, n_dropped;
    logic [tdpb_pkg::STAMP_W-1:0]      r_start_out, n_start_out;

    // ring memory
    logic [tdpb_pkg::STAMP_W-1:0]      r_ring [DEPTH];
    logic [tdpb_pkg::STAMP_W-1:0]      r_rd_data;
    logic [AW-1:0]                     rd_addr;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [tdpb_pkg::STAMP_W-1:0]      wr_data;

    logic                              accept;
    logic [AW-1:0]                     head_inc;
    logic [SW-1:0]                     tail_sum;
    logic [SW-1:0]                     tail_wrap;
    logic                              full;
    logic [tdpb_pkg::STAMP_W-1:0]      start_pick;
    logic [tdpb_pkg::STAMP_W:0]        finish_sum;
    logic [tdpb_pkg::STAMP_W-1:0]      finish_sat;

    assign accept   = i_start && !o_busy;
    assign head_inc = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);

    // slot of the new tail: head + occupancy, folded once
    assign tail_sum  = SW'(r_head) + SW'(r_occ);
    assign tail_wrap = (tail_sum >= SUM_DEPTH) ? tail_sum - SUM_DEPTH : tail_sum;

    // capacity above DEPTH saturates at DEPTH
    assign full = (CMPW'(r_occ) >= CMPW'(r_capacity)) || (r_occ == OCC_FULL);

    assign start_pick = (r_occ == '0) ? r_arrival : r_last;
    assign finish_sum = {1'b0, start_pick}
                        + {{(tdpb_pkg::STAMP_W + 1 - tdpb_pkg::SERVICE_W){1'b0}}, r_service};
    assign finish_sat = finish_sum[tdpb_pkg::STAMP_W] ? '1
                                                     : finish_sum[tdpb_pkg::STAMP_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_last      = r_last;
        n_done      = 1'b0;
        n_dropped   = r_dropped;
        n_start_out = r_start_out;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = tail_wrap[AW-1:0];
        wr_data     = finish_sat;
        case (r_state)
            tdpb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tdpb_pkg::ST_READ;
                end
            end
            tdpb_pkg::ST_READ: begin
                // fetch the head entry unless the ring is empty
                if (r_occ == '0) begin
                    n_state = tdpb_pkg::ST_DECIDE;
                end else begin
                    n_state = tdpb_pkg::ST_CHECK;
                end
            end
            tdpb_pkg::ST_CHECK: begin
                if (r_rd_data <= r_arrival) begin
                    // retire the head and fetch the next one
                    n_head  = head_inc;
                    n_occ   = r_occ - CW'(1);
                    rd_addr = head_inc;
                    if (r_occ == CW'(1)) begin
                        n_state = tdpb_pkg::ST_DECIDE;
                    end
                end else begin
                    n_state = tdpb_pkg::ST_DECIDE;
                end
            end
            tdpb_pkg::ST_DECIDE: begin
                n_state = tdpb_pkg::ST_IDLE;
                n_done  = 1'b1;
                if (full) begin
                    n_dropped   = 1'b1;
                    n_start_out = '0;
                end else begin
                    // append the finish time at the tail
                    n_dropped   = 1'b0;
                    n_start_out = start_pick;
                    n_occ       = r_occ + CW'(1);
                    n_last      = finish_sat;
                    wr_en       = 1'b1;
                end
            end
            default: begin
                n_state = tdpb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpb_pkg::ST_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_done  <= n_done;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_dropped   <= n_dropped;
        r_start_out <= n_start_out;
        if (accept) begin
            r_arrival <= i_arrival_stamp;
            r_service <= i_service_length;
        end
    end

    // ring memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    assign o_busy        = (r_state != tdpb_pkg::ST_IDLE);
    assign o_done        = r_done;
    assign o_dropped     = r_dropped;
    assign o_start_stamp = r_start_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TDPB_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, accept, r_state == tdpb_pkg::ST_READ)
    `TDPB_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `TDPB_ASSERT_SAME(a_drop_zero, i_clk, i_rst_n, o_done && o_dropped, o_start_stamp == '0)
    `TDPB_ASSERT_SAME(a_check_occupied, i_clk, i_rst_n,
                      r_state == tdpb_pkg::ST_CHECK, r_occ != '0)
    `TDPB_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, wr_en, r_occ == $past(r_occ) + CW'(1))

endmodule
`default_nettype wire
